### sv/midpoint_ellipse_raster_macros.svh
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster_macros.svh
// Assertion macros for the ellipse rasteriser; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTER_MACROS_SVH

`ifndef SYNTHESIS
// plain property, clocked on clk, off during reset
`define MER_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ellipse raster check failed");
// pre in one cycle implies post in the next
`define MER_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ellipse raster sequence check failed");
`else
`define MER_CHECK(lbl, prop)
`define MER_NEXT(lbl, pre, post)
`endif

`endif

### sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Widths, command codes and controller/datapath structs for the rasteriser.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int RADIUS_BITS = 11;
	localparam int COORD_BITS  = 12;
	localparam int COLOR_BITS  = 32;
	localparam int OUT_BITS    = COORD_BITS + 2;
	localparam int X_BITS      = RADIUS_BITS + 1;
	localparam int Y_BITS      = RADIUS_BITS + 2;
	localparam int SQ_BITS     = 2 * RADIUS_BITS;
	localparam int SLOPE_BITS  = 3 * RADIUS_BITS + 3;
	localparam int DEC_BITS    = 4 * RADIUS_BITS + 4;
	localparam int MUL_BITS    = 2 * RADIUS_BITS + 4;

	localparam int IN_BITS        = 2 * RADIUS_BITS + 2 * COORD_BITS + COLOR_BITS;
	localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_PAY_BITS   = 8 * OUT_BITS + COLOR_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_PAY_BITS + 7) / 8) * 8;

	// input word kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// multiplier operand selection
	localparam logic [2:0] MUL_RX_RX     = 3'd0;
	localparam logic [2:0] MUL_RY_RY     = 3'd1;
	localparam logic [2:0] MUL_RXSQ_RY   = 3'd2;
	localparam logic [2:0] MUL_A_A       = 3'd3;
	localparam logic [2:0] MUL_RYSQ_P    = 3'd4;
	localparam logic [2:0] MUL_B_B       = 3'd5;
	localparam logic [2:0] MUL_RXSQ_P    = 3'd6;
	localparam logic [2:0] MUL_RXSQ_RYSQ = 3'd7;

	// decision register operations
	localparam logic [2:0] DEC_HOLD = 3'd0;
	localparam logic [2:0] DEC_INIT = 3'd1;
	localparam logic [2:0] DEC_STEP = 3'd2;
	localparam logic [2:0] DEC_SET  = 3'd3;
	localparam logic [2:0] DEC_ADD  = 3'd4;
	localparam logic [2:0] DEC_SUB  = 3'd5;

	typedef struct packed {
		logic       load_start;
		logic       step_pos;
		logic       cap_out;
		logic [2:0] mul_sel;
		logic       rxsq_ld;
		logic       rysq_ld;
		logic [2:0] dec_op;
		logic       set_r2;
	} mer_cmd_t;

	typedef struct packed {
		logic region_two;
		logic r1_done;
		logic y_neg;
	} mer_stat_t;

endpackage

### sv/mer_dpath.sv
// ----------------------------------------------------------------------------
// mer_dpath
// Position, slope and decision registers, shared multiplier, output capture.
// ----------------------------------------------------------------------------
module mer_dpath
	import mer_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  mer_cmd_t               cmd,
	output mer_stat_t              stat,
	input  logic [RADIUS_BITS-1:0] in_rx,
	input  logic [RADIUS_BITS-1:0] in_ry,
	input  logic [COORD_BITS-1:0]  in_cx,
	input  logic [COORD_BITS-1:0]  in_cy,
	input  logic [COLOR_BITS-1:0]  in_color,
	output logic [OUT_BITS-1:0]    out_xp,
	output logic [OUT_BITS-1:0]    out_xn,
	output logic [OUT_BITS-1:0]    out_yp,
	output logic [OUT_BITS-1:0]    out_yn,
	output logic [COLOR_BITS-1:0]  out_color
);

	logic [RADIUS_BITS-1:0]       rad_x_q;
	logic [X_BITS-1:0]            step_x_q;
	logic signed [Y_BITS-1:0]     step_y_q;
	logic signed [SLOPE_BITS-1:0] slope_dx_q;
	logic signed [SLOPE_BITS-1:0] slope_dy_q;
	logic [DEC_BITS-1:0]          dec_q;
	logic [SQ_BITS-1:0]           rx_sq_q;
	logic [SQ_BITS-1:0]           ry_sq_q;
	logic [COORD_BITS-1:0]        cx_q;
	logic [COORD_BITS-1:0]        cy_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         region_two_q;
	logic [DEC_BITS-1:0]          mul_q;
	logic [OUT_BITS-1:0]          xp_q, xn_q, yp_q, yn_q;
	logic [COLOR_BITS-1:0]        ocolor_q;

	logic [MUL_BITS-1:0]          mul_a, mul_b;
	logic [2*MUL_BITS-1:0]        mul_p;
	logic                         dec_neg, dec_pos, move_x, move_y;
	logic signed [SLOPE_BITS-1:0] dx_inc, dy_dec;
	logic [DEC_BITS-1:0]          t_dx, t_dy, t_sq, dec_step, dec_init;
	logic [Y_BITS:0]              b_w, b_abs;
	logic [OUT_BITS-1:0]          x_ext, y_ext;

	// branch of the midpoint step, taken from the decision before update
	assign dec_neg = dec_q[DEC_BITS-1];
	assign dec_pos = !dec_neg && (dec_q != '0);
	assign move_x  = !region_two_q || !dec_pos;
	assign move_y  = region_two_q || !dec_neg;

	assign dx_inc = {{(SLOPE_BITS-SQ_BITS-1){1'b0}}, ry_sq_q, 1'b0};
	assign dy_dec = {{(SLOPE_BITS-SQ_BITS-1){1'b0}}, rx_sq_q, 1'b0};

	// decision update once dx/dy carry their new values (scaled by 4)
	always_comb begin
		t_dx = move_x ? {{(DEC_BITS-SLOPE_BITS-2){slope_dx_q[SLOPE_BITS-1]}}, slope_dx_q, 2'b00}
		              : '0;
		t_dy = move_y ? {{(DEC_BITS-SLOPE_BITS-2){slope_dy_q[SLOPE_BITS-1]}}, slope_dy_q, 2'b00}
		              : '0;
		t_sq = region_two_q ? {{(DEC_BITS-SQ_BITS-2){1'b0}}, rx_sq_q, 2'b00}
		                    : {{(DEC_BITS-SQ_BITS-2){1'b0}}, ry_sq_q, 2'b00};
		dec_step = dec_q + t_dx - t_dy + t_sq;
	end

	// 4ry^2 - 4rx^2*ry + rx^2, with rx^2*ry in mul_q
	assign dec_init = {{(DEC_BITS-SQ_BITS-2){1'b0}}, ry_sq_q, 2'b00}
	                - {mul_q[DEC_BITS-3:0], 2'b00}
	                + {{(DEC_BITS-SQ_BITS){1'b0}}, rx_sq_q};

	// |y - 1| for the region-two restart
	assign b_w   = {step_y_q[Y_BITS-1], step_y_q} - {{Y_BITS{1'b0}}, 1'b1};
	assign b_abs = b_w[Y_BITS] ? (~b_w + {{Y_BITS{1'b0}}, 1'b1}) : b_w;

	always_comb begin
		case (cmd.mul_sel)
			MUL_RX_RX: begin
				mul_a = MUL_BITS'(rad_x_q);
				mul_b = MUL_BITS'(rad_x_q);
			end
			MUL_RY_RY: begin
				mul_a = MUL_BITS'(step_y_q[RADIUS_BITS-1:0]);
				mul_b = MUL_BITS'(step_y_q[RADIUS_BITS-1:0]);
			end
			MUL_RXSQ_RY: begin
				mul_a = MUL_BITS'(rx_sq_q);
				mul_b = MUL_BITS'(step_y_q[RADIUS_BITS-1:0]);
			end
			MUL_A_A: begin
				mul_a = MUL_BITS'({step_x_q, 1'b1});
				mul_b = MUL_BITS'({step_x_q, 1'b1});
			end
			MUL_RYSQ_P: begin
				mul_a = MUL_BITS'(ry_sq_q);
				mul_b = mul_q[MUL_BITS-1:0];
			end
			MUL_B_B: begin
				mul_a = MUL_BITS'(b_abs);
				mul_b = MUL_BITS'(b_abs);
			end
			MUL_RXSQ_P: begin
				mul_a = MUL_BITS'(rx_sq_q);
				mul_b = mul_q[MUL_BITS-1:0];
			end
			MUL_RXSQ_RYSQ: begin
				mul_a = MUL_BITS'(rx_sq_q);
				mul_b = MUL_BITS'(ry_sq_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_two_q <= 1'b0;
		end else if (cmd.load_start) begin
			region_two_q <= 1'b0;
		end else if (cmd.set_r2) begin
			region_two_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p[DEC_BITS-1:0];

		if (cmd.load_start) begin
			rad_x_q    <= in_rx;
			cx_q       <= in_cx;
			cy_q       <= in_cy;
			color_q    <= in_color;
			step_x_q   <= '0;
			step_y_q   <= {2'b00, in_ry};
			slope_dx_q <= '0;
		end else if (cmd.step_pos) begin
			if (move_x) begin
				step_x_q   <= step_x_q + X_BITS'(1);
				slope_dx_q <= slope_dx_q + dx_inc;
			end
			if (move_y) begin
				step_y_q <= step_y_q - Y_BITS'(1);
			end
		end

		if (cmd.dec_op == DEC_INIT) begin
			slope_dy_q <= {mul_q[SLOPE_BITS-2:0], 1'b0};
		end else if (cmd.step_pos && move_y) begin
			slope_dy_q <= slope_dy_q - dy_dec;
		end

		if (cmd.rxsq_ld) begin
			rx_sq_q <= mul_q[SQ_BITS-1:0];
		end
		if (cmd.rysq_ld) begin
			ry_sq_q <= mul_q[SQ_BITS-1:0];
		end

		case (cmd.dec_op)
			DEC_INIT: dec_q <= dec_init;
			DEC_STEP: dec_q <= dec_step;
			DEC_SET:  dec_q <= mul_q;
			DEC_ADD:  dec_q <= dec_q + {mul_q[DEC_BITS-3:0], 2'b00};
			DEC_SUB:  dec_q <= dec_q - {mul_q[DEC_BITS-3:0], 2'b00};
			default:  dec_q <= dec_q;
		endcase

		if (cmd.cap_out) begin
			xp_q     <= OUT_BITS'(cx_q) + x_ext;
			xn_q     <= OUT_BITS'(cx_q) - x_ext;
			yp_q     <= OUT_BITS'(cy_q) + y_ext;
			yn_q     <= OUT_BITS'(cy_q) - y_ext;
			ocolor_q <= color_q;
		end
	end

	assign x_ext = OUT_BITS'(step_x_q);
	assign y_ext = {{(OUT_BITS-Y_BITS){step_y_q[Y_BITS-1]}}, step_y_q};

	assign stat.region_two = region_two_q;
	assign stat.r1_done    = !(slope_dx_q < slope_dy_q);
	assign stat.y_neg      = step_y_q[Y_BITS-1];

	assign out_xp    = xp_q;
	assign out_xn    = xn_q;
	assign out_yp    = yp_q;
	assign out_yn    = yn_q;
	assign out_color = ocolor_q;

endmodule

### sv/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: start set-up, step handling, region-two restart, output word.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_raster_macros.svh"

module mer_ctrl
	import mer_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_opcode,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_last,
	output mer_cmd_t  cmd,
	input  mer_stat_t stat
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MRX       = 4'd1;
	localparam logic [3:0] ST_MRY       = 4'd2;
	localparam logic [3:0] ST_MDY       = 4'd3;
	localparam logic [3:0] ST_INIT      = 4'd4;
	localparam logic [3:0] ST_CHK_START = 4'd5;
	localparam logic [3:0] ST_CHK_STEP  = 4'd6;
	localparam logic [3:0] ST_R1        = 4'd7;
	localparam logic [3:0] ST_R2        = 4'd8;
	localparam logic [3:0] ST_R3        = 4'd9;
	localparam logic [3:0] ST_R4        = 4'd10;
	localparam logic [3:0] ST_R5        = 4'd11;
	localparam logic [3:0] ST_R6        = 4'd12;

	logic [3:0] st_q, st_nxt;
	logic       busy_q, out_valid_q, last_q;
	logic       accept, need_r2, last;

	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign need_r2  = !stat.region_two && stat.r1_done;
	assign last     = (stat.region_two || stat.r1_done) && stat.y_neg;

	always_comb begin
		cmd    = '0;
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_opcode == OP_START) begin
						cmd.load_start = 1'b1;
						st_nxt         = ST_MRX;
					end else if (busy_q) begin
						cmd.step_pos = 1'b1;
						cmd.cap_out  = 1'b1;
						st_nxt       = ST_CHK_STEP;
					end
				end
			end
			ST_MRX: begin
				cmd.mul_sel = MUL_RX_RX;
				st_nxt      = ST_MRY;
			end
			ST_MRY: begin
				cmd.rxsq_ld = 1'b1;
				cmd.mul_sel = MUL_RY_RY;
				st_nxt      = ST_MDY;
			end
			ST_MDY: begin
				cmd.rysq_ld = 1'b1;
				cmd.mul_sel = MUL_RXSQ_RY;
				st_nxt      = ST_INIT;
			end
			ST_INIT: begin
				cmd.dec_op = DEC_INIT;
				st_nxt     = ST_CHK_START;
			end
			ST_CHK_START: begin
				st_nxt = need_r2 ? ST_R1 : ST_IDLE;
			end
			ST_CHK_STEP: begin
				cmd.dec_op = DEC_STEP;
				st_nxt     = need_r2 ? ST_R1 : ST_IDLE;
			end
			ST_R1: begin
				cmd.mul_sel = MUL_A_A;
				st_nxt      = ST_R2;
			end
			ST_R2: begin
				cmd.mul_sel = MUL_RYSQ_P;
				st_nxt      = ST_R3;
			end
			ST_R3: begin
				cmd.dec_op  = DEC_SET;
				cmd.mul_sel = MUL_B_B;
				st_nxt      = ST_R4;
			end
			ST_R4: begin
				cmd.mul_sel = MUL_RXSQ_P;
				st_nxt      = ST_R5;
			end
			ST_R5: begin
				cmd.dec_op  = DEC_ADD;
				cmd.mul_sel = MUL_RXSQ_RYSQ;
				st_nxt      = ST_R6;
			end
			ST_R6: begin
				cmd.dec_op = DEC_SUB;
				cmd.set_r2 = 1'b1;
				st_nxt     = ST_IDLE;
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cmd.load_start) begin
				busy_q <= 1'b1;
			end else if (st_q == ST_CHK_STEP && last) begin
				busy_q <= 1'b0;
			end
			if (st_q == ST_CHK_STEP) begin
				out_valid_q <= 1'b1;
				last_q      <= last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = last_q;

	`MER_CHECK(a_step_when_busy, (st_q == ST_CHK_STEP) |-> busy_q)
	`MER_CHECK(a_out_free_on_step, (st_q == ST_CHK_STEP) |-> !out_valid_q)
	`MER_CHECK(a_last_ends_run, (out_valid_q && last_q) |-> !busy_q)
	`MER_NEXT(a_restart_sets_r2, st_q == ST_R6, stat.region_two)

endmodule

### sv/midpoint_ellipse_raster.sv
// Start word: set-up states MRX to CHK_START, plus restart if a radius is zero.
// Step word: result valid after state CHK_STEP; next word waits for IDLE.
// A step that ends region one adds the decision restart, states R1 to R6.
// Start set-up and restart are bound by the single shared 26x26 multiplier.
// arst_n clears sequencer, busy, region flag and output valid; idle after reset.
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster
// Midpoint ellipse rasteriser: one start word loads radii, centre and colour;
// each following step word returns one group of four mirrored points.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster
	import mer_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// input words
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// radius_x, radius_y, centre_x, centre_y, pixel_color (low bit up), zero pad
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	// opcode: 0 start, 1 step
	input  logic                      s_tuser,
	// result words
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// px_pos_x, px_pos_y, nx_pos_x, nx_pos_y, px_neg_x, px_neg_y,
	// nx_neg_x, nx_neg_y, point_color (low bit up)
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	// last_group
	output logic                      m_tlast
);

	localparam int RY_LO = RADIUS_BITS;
	localparam int CX_LO = 2 * RADIUS_BITS;
	localparam int CY_LO = CX_LO + COORD_BITS;
	localparam int CL_LO = CY_LO + COORD_BITS;

	mer_cmd_t  cmd;
	mer_stat_t stat;

	logic [OUT_BITS-1:0]   xp, xn, yp, yn;
	logic [COLOR_BITS-1:0] color;

	// controller: owns the handshakes, busy flag and output-valid register
	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_opcode (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: ellipse state, multiplier and captured point group
	mer_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_rx     (s_tdata[RADIUS_BITS-1:0]),
		.in_ry     (s_tdata[RY_LO +: RADIUS_BITS]),
		.in_cx     (s_tdata[CX_LO +: COORD_BITS]),
		.in_cy     (s_tdata[CY_LO +: COORD_BITS]),
		.in_color  (s_tdata[CL_LO +: COLOR_BITS]),
		.out_xp    (xp),
		.out_xn    (xn),
		.out_yp    (yp),
		.out_yn    (yn),
		.out_color (color)
	);

	// the four corners share two column and two row values
	assign m_tdata = OUT_TDATA_BITS'({color, yn, xn, yn, xp, yp, xn, yp, xp});

endmodule

### bench/ellipse_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_point_checker
// Watches both word channels of the ellipse rasteriser, traces the ellipse
// from each accepted input word and compares every result word field by field.
// ----------------------------------------------------------------------------
module ellipse_point_checker
	import mer_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	input  logic                      s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_TDATA_BITS-1:0] m_tdata,
	input  logic                      m_tlast,
	output int                        mismatches,
	output int                        groups_due
);

	localparam int MAX_REPORTS = 200;

	// coord[0] sits in the low bits, as on m_tdata
	typedef struct packed {
		logic                     last;
		logic [COLOR_BITS-1:0]    color;
		logic [7:0][OUT_BITS-1:0] coord;
	} point_group_t;

	string coord_name [8] = '{"px_pos_x", "px_pos_y", "nx_pos_x", "nx_pos_y",
		"px_neg_x", "px_neg_y", "nx_neg_x", "nx_neg_y"};

	// traced ellipse; wide enough that every true value is exact
	logic                  drawing;
	logic                  in_r2;
	longint                cur_x;
	longint                cur_y;
	logic [63:0]           grad_x;
	logic [63:0]           grad_y;
	logic [63:0]           dvar;
	logic [63:0]           rx_sq;
	logic [63:0]           ry_sq;
	logic [COORD_BITS-1:0] ctr_x;
	logic [COORD_BITS-1:0] ctr_y;
	logic [COLOR_BITS-1:0] ink;
	point_group_t          due_groups [$];
	int                    reports;

	task automatic note_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (reports < MAX_REPORTS) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
			reports++;
		end
	endtask

	// region one ends once dx catches dy; the figure ends when y drops below 0
	task automatic close_region();
		logic [63:0] a;
		logic [63:0] b;
		if (!in_r2 && !(grad_x < grad_y)) begin
			a = 64'(2 * cur_x + 1);
			b = 64'(cur_y - 1);
			in_r2 = 1'b1;
			dvar = ry_sq * a * a + 64'd4 * rx_sq * b * b - 64'd4 * rx_sq * ry_sq;
		end
		if (in_r2 && cur_y < 0)
			drawing = 1'b0;
	endtask

	task automatic trace_word(input logic op, input logic [IN_TDATA_BITS-1:0] w);
		logic [63:0]  rx;
		logic [63:0]  ry;
		point_group_t g;
		if (op == OP_START) begin
			rx    = 64'(w[0 +: RADIUS_BITS]);
			ry    = 64'(w[RADIUS_BITS +: RADIUS_BITS]);
			ctr_x = w[2 * RADIUS_BITS +: COORD_BITS];
			ctr_y = w[2 * RADIUS_BITS + COORD_BITS +: COORD_BITS];
			ink   = w[2 * RADIUS_BITS + 2 * COORD_BITS +: COLOR_BITS];
			rx_sq  = rx * rx;
			ry_sq  = ry * ry;
			cur_x  = 0;
			cur_y  = longint'(ry);
			grad_x = '0;
			grad_y = 64'd2 * rx_sq * ry;
			dvar   = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
			in_r2   = 1'b0;
			drawing = 1'b1;
			close_region();
			// a fresh figure always has a first group, even at zero height
			drawing = 1'b1;
		end else if (drawing) begin
			g.color    = ink;
			g.coord[0] = OUT_BITS'(longint'(ctr_x) + cur_x);
			g.coord[1] = OUT_BITS'(longint'(ctr_y) + cur_y);
			g.coord[2] = OUT_BITS'(longint'(ctr_x) - cur_x);
			g.coord[3] = g.coord[1];
			g.coord[4] = g.coord[0];
			g.coord[5] = OUT_BITS'(longint'(ctr_y) - cur_y);
			g.coord[6] = g.coord[2];
			g.coord[7] = g.coord[5];
			if (!in_r2) begin
				cur_x++;
				grad_x += 64'd2 * ry_sq;
				if (dvar[63]) begin
					dvar += 64'd4 * grad_x + 64'd4 * ry_sq;
				end else begin
					cur_y--;
					grad_y -= 64'd2 * rx_sq;
					dvar += 64'd4 * grad_x - 64'd4 * grad_y + 64'd4 * ry_sq;
				end
			end else begin
				cur_y--;
				grad_y -= 64'd2 * rx_sq;
				if (!dvar[63] && dvar != 64'd0) begin
					dvar += 64'd4 * rx_sq - 64'd4 * grad_y;
				end else begin
					cur_x++;
					grad_x += 64'd2 * ry_sq;
					dvar += 64'd4 * grad_x - 64'd4 * grad_y + 64'd4 * rx_sq;
				end
			end
			close_region();
			g.last = !drawing;
			due_groups = {due_groups, g};
		end
	endtask

	always @(posedge clk) begin
		point_group_t want;
		if (!arst_n) begin
			drawing    = 1'b0;
			in_r2      = 1'b0;
			cur_x      = 0;
			cur_y      = 0;
			grad_x     = '0;
			grad_y     = '0;
			dvar       = '0;
			rx_sq      = '0;
			ry_sq      = '0;
			ctr_x      = '0;
			ctr_y      = '0;
			ink        = '0;
			reports    = 0;
			mismatches = 0;
			due_groups.delete();
		end else begin
			if (s_tvalid && s_tready)
				trace_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (due_groups.size() == 0) begin
					note_mismatch("group with none due, px_pos_x", '0,
						64'(m_tdata[0 +: OUT_BITS]));
				end else begin
					want = due_groups.pop_front();
					for (int i = 0; i < 8; i++)
						if (m_tdata[i * OUT_BITS +: OUT_BITS] !== want.coord[i])
							note_mismatch(coord_name[i], 64'(want.coord[i]),
								64'(m_tdata[i * OUT_BITS +: OUT_BITS]));
					if (m_tdata[8 * OUT_BITS +: COLOR_BITS] !== want.color)
						note_mismatch("point_color", 64'(want.color),
							64'(m_tdata[8 * OUT_BITS +: COLOR_BITS]));
					if (m_tlast !== want.last)
						note_mismatch("last_group", 64'(want.last), 64'(m_tlast));
				end
			end
		end
		groups_due = due_groups.size();
	end

endmodule

### bench/midpoint_ellipse_raster_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster_tb
// Drives start and step words into the ellipse rasteriser, with random gaps
// and stalls on both channels and one long output hold-off; the checker
// beside the block traces each ellipse and compares every point group.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster_tb
	import mer_pkg::*;
();

	localparam int RANDOM_WORDS = 625;  // words in the random part, idle steps included
	localparam int HOLD_CYCLES  = 300;  // long output hold-off, once
	localparam int STALL_LIMIT  = 3000; // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 20;   // covers a start set-up plus the result delay

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
	logic                      s_tuser  = OP_STEP;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tlast;

	int mismatches;
	int groups_due;
	int words_sent   = 0;
	int src_gap_pct  = 24;
	int sink_gap_pct = 79;
	bit hold_armed   = 1'b0;
	bit hold_done    = 1'b0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midpoint_ellipse_raster i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ellipse_point_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.groups_due (groups_due)
	);

	// Watchdog: nothing moving on either channel for too long means a hang,
	// or a group the block never delivers.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[midpoint_ellipse_raster] ERROR");
			$finish;
		end
	end

	// Result sink. Random stalls at the current rate; once armed, a single
	// long hold-off so the block backs up and holds its input off.
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_gap_pct);
		end
	end

	// Input fields from the low bit up; the byte pad stays zero.
	function automatic logic [IN_TDATA_BITS-1:0] pack_word(input int unsigned rx,
		input int unsigned ry, input int unsigned cx, input int unsigned cy,
		input logic [COLOR_BITS-1:0] ink);
		logic [IN_TDATA_BITS-1:0] w;
		w = '0;
		w[0 +: RADIUS_BITS]                              = RADIUS_BITS'(rx);
		w[RADIUS_BITS +: RADIUS_BITS]                    = RADIUS_BITS'(ry);
		w[2 * RADIUS_BITS +: COORD_BITS]                 = COORD_BITS'(cx);
		w[2 * RADIUS_BITS + COORD_BITS +: COORD_BITS]    = COORD_BITS'(cy);
		w[2 * RADIUS_BITS + 2 * COORD_BITS +: COLOR_BITS] = ink;
		return w;
	endfunction

	// Called just after a falling edge, returns just after one. Gaps are
	// decided before the word goes up, so tvalid is never dropped and raised
	// in the same step.
	task automatic send_word(input logic op, input logic [IN_TDATA_BITS-1:0] w);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic start_figure(input int unsigned rx, input int unsigned ry,
		input int unsigned cx, input int unsigned cy, input logic [COLOR_BITS-1:0] ink);
		send_word(OP_START, pack_word(rx, ry, cx, cy, ink));
	endtask

	// step words carry don't-care payload; random, so the block must ignore it
	task automatic step_figure();
		send_word(OP_STEP, pack_word($urandom, $urandom, $urandom, $urandom, $urandom));
	endtask

	// Mostly small ellipses run to the end, plus a few stray steps once idle;
	// some are cut short by the next start; a few use radii over the full
	// range and are abandoned after a handful of groups.
	task automatic random_figure();
		int unsigned pick;
		int unsigned rx;
		int unsigned ry;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 15) begin
			rx = $urandom_range(2047);
			ry = $urandom_range(2047);
			n  = $urandom_range(1, 12);
		end else begin
			rx = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 14);
			ry = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 14);
			if (pick < 30)
				n = $urandom_range(0, rx + ry);
			else
				n = rx + ry + $urandom_range(1, 3);
		end
		start_figure(rx, ry, $urandom_range(4095), $urandom_range(4095), $urandom);
		repeat (n) step_figure();
	endtask

	initial begin
		int base;
		int done;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words
		step_figure();                                   // step while idle: dropped
		start_figure(0, 0, 0, 0, 32'hFFFF_FFFF);         // zero radii: one group
		step_figure();
		step_figure();                                   // figure done: dropped
		start_figure(2047, 2047, 4095, 4095, 32'h0000_0000);
		repeat (3) step_figure();
		start_figure(2047, 2047, 0, 0, 32'hA5A5_5A5A);   // restart while busy, centre-x wraps
		repeat (2) step_figure();
		start_figure(0, 3, 4095, 0, 32'h1234_5678);      // flat width: one group per row
		repeat (5) step_figure();
		start_figure(3, 0, 0, 4095, 32'h8765_4321);      // flat height: single group
		repeat (2) step_figure();
		start_figure(1, 2047, 2047, 2047, 32'hFFFF_0000); // region two almost at once
		repeat (4) step_figure();

		// Random part in three thirds: quick sender and busy receiver, then
		// the reverse, then full rate with the long hold-off.
		base = words_sent;
		done = 0;
		while (done < RANDOM_WORDS) begin
			if (done >= 2 * RANDOM_WORDS / 3) begin
				src_gap_pct  = 0;
				sink_gap_pct = 0;
				hold_armed   = 1'b1;
			end else if (done >= RANDOM_WORDS / 3) begin
				src_gap_pct  = 79;
				sink_gap_pct = 24;
			end
			random_figure();
			done = words_sent - base;
		end
		s_tvalid <= 1'b0;

		// drain: wait for every traced group, then let the block settle
		while (groups_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("[midpoint_ellipse_raster] OK");
		else
			$display("[midpoint_ellipse_raster] ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/mer_pkg.sv
sv/mer_dpath.sv
sv/mer_ctrl.sv
sv/midpoint_ellipse_raster.sv
bench/ellipse_point_checker.sv
bench/midpoint_ellipse_raster_tb.sv
